@@ hw/rtl/ase_pkg.sv @@
// ----------------------------------------------------------------------------
// ase_pkg - shared constants for the approximate Sobel edge stream
// Sizes of the line store, counters and configuration port.
// ----------------------------------------------------------------------------
package ase_pkg;

    localparam int MaxWidth  = 2048;
    localparam int MaxRows   = 4096;
    localparam int LineDepth = 2 * MaxWidth + 3;
    localparam int AddrW     = $clog2(LineDepth);
    localparam int WidthW    = 12;
    localparam int RowsW     = 13;
    localparam int CountW    = 24;
    localparam int SumW      = 13;
    localparam int CfgIdxW   = 1;
    localparam int CfgDataW  = 13;
    localparam int KW        = 4;

    localparam logic [CfgIdxW-1:0] CFG_LINE_WIDTH = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_ROWS = 1'b1;

endpackage

@@ hw/rtl/ase_ram.sv @@
// ----------------------------------------------------------------------------
// ase_ram - generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ase_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/approx_sobel_edge_stream.sv @@
// ----------------------------------------------------------------------------
// approx_sobel_edge_stream - approximate Sobel edge detector on a pixel stream
//
// Pixels come in on the slave stream in raster order (tuser low) with a pair
// of error masks; tuser high marks a flush transfer that drains one pending
// result after the whole frame is in. Each pixel is turned to gray and kept
// in a ring line store. The result for a pixel leaves on the master stream
// once the pixel one row plus one column later has arrived, carrying the two
// absolute Sobel gradients (wrapped to 8 bits) and their saturated magnitude;
// tlast marks the last pixel of the frame.
// An item without a result keeps the block idle and ready for the next
// item. An item with a result runs line store reads feeding the add/scale
// accumulators, squaring of both gradients and square root bit steps on the
// one shared 8x8 multiplier, and then a load of the output register.
// tready stays low for the whole of that sequence.
// A finished result waits in the output register when the receiver stalls;
// the next item is then accepted but its result waits for that register.
// Reset (synchronous, active low) sets line width 640 and 480 rows and
// restarts the frame. Any configuration write restarts the frame as well,
// and tready drops for one cycle after it while the frame size settles.
// ----------------------------------------------------------------------------
module approx_sobel_edge_stream (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [ase_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [ase_pkg::CfgDataW-1:0]  i_cfg_data,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: red[7:0], green[15:8], blue[23:16], err_bits_h[31:24], err_bits_v[39:32]
    input  logic [39:0]                   s_axis_tdata,
    // tuser: req_type[0]
    input  logic                          s_axis_tuser,
    // Output stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: grad_h[7:0], grad_v[15:8], magnitude[23:16]
    output logic [23:0]                   m_axis_tdata,
    // tlast: frame_end
    output logic                          m_axis_tlast
);

    localparam int AW = ase_pkg::AddrW;
    localparam int CW = ase_pkg::CountW;
    localparam int SW = ase_pkg::SumW;
    localparam int OW = AW + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_TAP, S_SQH, S_SQV, S_ROOT, S_PUT
    } t_state;

    // One accumulation step: add a tap times a small kernel weight, then
    // optionally scale by 257/256 with truncation toward zero.
    function automatic logic signed [SW-1:0] acc_step(
        input logic signed [SW-1:0] s,
        input logic [7:0]           px,
        input logic signed [2:0]    coef,
        input logic                 first,
        input logic                 scale
    );
        logic signed [SW-1:0] p;
        logic signed [SW-1:0] t;
        logic [SW-1:0]        mag;
        p = '0;
        case (coef)
            3'sd1:   p = $signed({{(SW-8){1'b0}}, px});
            -3'sd1:  p = -$signed({{(SW-8){1'b0}}, px});
            3'sd2:   p = $signed({{(SW-9){1'b0}}, px, 1'b0});
            -3'sd2:  p = -$signed({{(SW-9){1'b0}}, px, 1'b0});
            default: p = '0;
        endcase
        t = first ? p : s + p;
        mag = t[SW-1] ? unsigned'(-t) : unsigned'(t);
        if (scale) begin
            mag = mag + (mag >> 8);
            t = t[SW-1] ? -$signed(mag) : $signed(mag);
        end
        return t;
    endfunction

    t_state r_state;
    logic   r_settle;

    logic [ase_pkg::WidthW-1:0] r_eff_w;
    logic [ase_pkg::RowsW-1:0]  r_eff_rows;
    logic [CW-1:0]              r_total;

    logic [CW-1:0] r_in_count, r_out_count;
    logic [AW-1:0] r_wp, r_cp;
    logic [ase_pkg::WidthW-1:0] r_col;
    logic [ase_pkg::RowsW-1:0]  r_row;

    logic [7:0]    r_err_h, r_err_v;
    logic [ase_pkg::KW-1:0] r_k;
    logic          r_tap_ok;
    logic signed [SW-1:0] r_sum_h, r_sum_v;
    logic [7:0]    r_gh, r_gv;
    logic [16:0]   r_sq;
    logic [7:0]    r_root;
    logic [2:0]    r_bit;

    logic          r_m_valid;
    logic [23:0]   r_m_data;
    logic          r_m_last;

    // Input side decode.
    logic          accept;
    logic [15:0]   gray_full;
    logic          take_px;
    logic [CW-1:0] in_next;
    logic          want_emit;

    assign s_axis_tready = (r_state == S_IDLE) && !r_settle;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign gray_full = 16'(16'd77 * s_axis_tdata[7:0]) + 16'(16'd151 * s_axis_tdata[15:8])
                     + 16'(16'd28 * s_axis_tdata[23:16]);
    assign take_px   = !s_axis_tuser && (r_in_count < r_total);
    assign in_next   = r_in_count + 1'b1;

    always_comb begin
        if (take_px) begin
            want_emit = {1'b0, in_next} >=
                        ({1'b0, r_out_count} + (CW+1)'(r_eff_w) + (CW+1)'(2));
        end else begin
            want_emit = (r_in_count == r_total) && (r_out_count < r_total);
        end
    end

    // Window tap addressing with zero padding at the image border.
    logic up_ok, down_ok, left_ok, right_ok;
    logic signed [OW-1:0] off, addr_s, ws;
    logic [AW-1:0] tap_addr;
    logic          tap_ok;

    assign up_ok    = r_row != '0;
    assign down_ok  = r_row != (r_eff_rows - 1'b1);
    assign left_ok  = r_col != '0;
    assign right_ok = r_col != (r_eff_w - 1'b1);
    assign ws       = $signed(OW'(r_eff_w));

    always_comb begin
        off    = '0;
        tap_ok = 1'b0;
        case (r_k)
            4'd0: begin off = -ws - $signed(OW'(1)); tap_ok = up_ok && left_ok;    end
            4'd1: begin off = -ws;                   tap_ok = up_ok;               end
            4'd2: begin off = -ws + $signed(OW'(1)); tap_ok = up_ok && right_ok;   end
            4'd3: begin off = -$signed(OW'(1));      tap_ok = left_ok;             end
            4'd4: begin off = '0;                    tap_ok = 1'b1;                end
            4'd5: begin off = $signed(OW'(1));       tap_ok = right_ok;            end
            4'd6: begin off = ws - $signed(OW'(1));  tap_ok = down_ok && left_ok;  end
            4'd7: begin off = ws;                    tap_ok = down_ok;             end
            4'd8: begin off = ws + $signed(OW'(1));  tap_ok = down_ok && right_ok; end
            default: begin off = '0;                 tap_ok = 1'b0;                end
        endcase
        addr_s = $signed(OW'(r_cp)) + off;
        if (addr_s < 0) begin
            tap_addr = AW'(addr_s + $signed(OW'(ase_pkg::LineDepth)));
        end else if (addr_s >= $signed(OW'(ase_pkg::LineDepth))) begin
            tap_addr = AW'(addr_s - $signed(OW'(ase_pkg::LineDepth)));
        end else begin
            tap_addr = AW'(addr_s);
        end
    end

    // Line store.
    logic [7:0] rd_data;

    ase_ram #(
        .Width (8),
        .Depth (ase_pkg::LineDepth)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept && take_px),
        .i_waddr (r_wp),
        .i_wdata (gray_full[15:8]),
        .i_raddr (tap_addr),
        .o_rdata (rd_data)
    );

    // Accumulation of the tap that was read on the previous cycle.
    logic [ase_pkg::KW-1:0] j;
    logic [7:0]             px;
    logic signed [2:0]      coef_h, coef_v;
    logic                   first, sc_h, sc_v;
    logic signed [SW-1:0]   n_sum_h, n_sum_v;

    assign j     = r_k - 1'b1;
    assign px    = r_tap_ok ? rd_data : 8'd0;
    assign first = (j == '0);
    assign sc_h  = !first && r_err_h[3'(j - 1'b1)];
    assign sc_v  = !first && r_err_v[3'(j - 1'b1)];

    // Horizontal weights 1 0 -1 2 0 -2 1 0 -1, vertical -1 -2 -1 0 0 0 1 2 1.
    always_comb begin
        case (j)
            4'd0, 4'd6: coef_h = 3'sd1;
            4'd2, 4'd8: coef_h = -3'sd1;
            4'd3:       coef_h = 3'sd2;
            4'd5:       coef_h = -3'sd2;
            default:    coef_h = 3'sd0;
        endcase
        case (j)
            4'd0, 4'd2: coef_v = -3'sd1;
            4'd1:       coef_v = -3'sd2;
            4'd6, 4'd8: coef_v = 3'sd1;
            4'd7:       coef_v = 3'sd2;
            default:    coef_v = 3'sd0;
        endcase
    end

    assign n_sum_h = acc_step(r_sum_h, px, coef_h, first, sc_h);
    assign n_sum_v = acc_step(r_sum_v, px, coef_v, first, sc_v);

    // The shared multiplier squares the gradients and then each trial root.
    logic [7:0]  mul_a;
    logic [15:0] mul_p;
    logic [7:0]  trial;
    logic [SW-1:0] abs_h, abs_v;

    assign trial = r_root | (8'd1 << r_bit);
    always_comb begin
        case (r_state)
            S_SQH:   mul_a = r_gh;
            S_SQV:   mul_a = r_gv;
            default: mul_a = trial;
        endcase
    end
    assign mul_p = 16'(mul_a * mul_a);
    assign abs_h = n_sum_h[SW-1] ? unsigned'(-n_sum_h) : unsigned'(n_sum_h);
    assign abs_v = n_sum_v[SW-1] ? unsigned'(-n_sum_v) : unsigned'(n_sum_v);

    // Output bookkeeping for the result being delivered.
    logic is_last;
    assign is_last = (r_out_count + 1'b1) == r_total;

    // The finished result moves into the output register once it is free.
    logic put_go;
    assign put_go = (r_state == S_PUT) && (!r_m_valid || m_axis_tready);

    logic [ase_pkg::WidthW-1:0] n_eff_w;
    logic [ase_pkg::RowsW-1:0]  n_eff_rows;

    always_comb begin
        n_eff_w = i_cfg_data[ase_pkg::WidthW-1:0];
        if (n_eff_w == '0) begin
            n_eff_w = ase_pkg::WidthW'(1);
        end else if (n_eff_w > ase_pkg::WidthW'(ase_pkg::MaxWidth)) begin
            n_eff_w = ase_pkg::WidthW'(ase_pkg::MaxWidth);
        end
        n_eff_rows = i_cfg_data[ase_pkg::RowsW-1:0];
        if (n_eff_rows == '0) begin
            n_eff_rows = ase_pkg::RowsW'(1);
        end else if (n_eff_rows > ase_pkg::RowsW'(ase_pkg::MaxRows)) begin
            n_eff_rows = ase_pkg::RowsW'(ase_pkg::MaxRows);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_settle    <= 1'b0;
            r_eff_w     <= ase_pkg::WidthW'(640);
            r_eff_rows  <= ase_pkg::RowsW'(480);
            r_total     <= CW'(640 * 480);
            r_in_count  <= '0;
            r_out_count <= '0;
            r_wp        <= '0;
            r_cp        <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_k         <= '0;
            r_bit       <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_total  <= CW'(r_eff_rows * r_eff_w);
            r_settle <= i_cfg_we;
            if (put_go) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                if (i_cfg_idx == ase_pkg::CFG_LINE_WIDTH) begin
                    r_eff_w <= n_eff_w;
                end else begin
                    r_eff_rows <= n_eff_rows;
                end
                r_in_count  <= '0;
                r_out_count <= '0;
                r_wp        <= '0;
                r_cp        <= '0;
                r_col       <= '0;
                r_row       <= '0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_err_h <= s_axis_tdata[31:24];
                        r_err_v <= s_axis_tdata[39:32];
                        r_k     <= '0;
                        if (take_px) begin
                            r_in_count <= in_next;
                            r_wp <= (r_wp == AW'(ase_pkg::LineDepth - 1)) ? '0 : r_wp + 1'b1;
                        end
                        if (want_emit) begin
                            r_state <= S_TAP;
                        end
                    end
                end
                S_TAP: begin
                    r_tap_ok <= tap_ok;
                    r_k      <= r_k + 1'b1;
                    if (r_k != '0) begin
                        r_sum_h <= n_sum_h;
                        r_sum_v <= n_sum_v;
                    end
                    if (r_k == ase_pkg::KW'(9)) begin
                        r_gh    <= abs_h[7:0];
                        r_gv    <= abs_v[7:0];
                        r_state <= S_SQH;
                    end
                end
                S_SQH: begin
                    r_sq    <= 17'(mul_p);
                    r_state <= S_SQV;
                end
                S_SQV: begin
                    r_sq    <= r_sq + 17'(mul_p);
                    r_root  <= '0;
                    r_bit   <= 3'd7;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (17'(mul_p) <= r_sq) begin
                        r_root <= trial;
                    end
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (put_go) begin
                        r_m_data  <= {r_root, r_gv, r_gh};
                        r_m_last  <= is_last;
                        r_state   <= S_IDLE;
                        if (is_last) begin
                            r_in_count  <= '0;
                            r_out_count <= '0;
                            r_wp        <= '0;
                            r_cp        <= '0;
                            r_col       <= '0;
                            r_row       <= '0;
                        end else begin
                            r_out_count <= r_out_count + 1'b1;
                            r_cp <= (r_cp == AW'(ase_pkg::LineDepth - 1)) ? '0 : r_cp + 1'b1;
                            if (r_col == r_eff_w - 1'b1) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

@@ dv/sobel_result_monitor.sv @@
// ----------------------------------------------------------------------------
// sobel_result_monitor - prediction and checking for the Sobel edge stream
// Watches the configuration port and both streams, keeps its own gray line
// store and frame counters, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module sobel_result_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ase_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [ase_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    // tdata: red[7:0], green[15:8], blue[23:16], err_bits_h[31:24], err_bits_v[39:32]
    input  logic [39:0]                   s_axis_tdata,
    // tuser: req_type[0]
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: grad_h[7:0], grad_v[15:8], magnitude[23:16]
    input  logic [23:0]                   m_axis_tdata,
    input  logic                          m_axis_tlast,
    output int                            o_fails,
    output int                            o_pending
);
    import ase_pkg::*;

    typedef struct packed {
        logic [7:0] grad_h;
        logic [7:0] grad_v;
        logic [7:0] mag;
        logic       frame_end;
    } edge_result_t;

    localparam int KernH[9] = '{1, 0, -1, 2, 0, -2, 1, 0, -1};
    localparam int KernV[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

    logic [7:0]        gray_ring [LineDepth];
    logic [WidthW-1:0] width_reg;
    logic [RowsW-1:0]  rows_reg;
    int unsigned       pix_in;
    int unsigned       res_out;
    edge_result_t      expected_q[$];

    assign o_pending = expected_q.size();

    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > MaxWidth) w = MaxWidth;
        return w;
    endfunction

    function automatic int unsigned eff_total();
        int unsigned r;
        r = rows_reg;
        if (r == 0) r = 1;
        if (r > MaxRows) r = MaxRows;
        return r * eff_width();
    endfunction

    function automatic logic [7:0] ring_at(input int unsigned idx);
        return gray_ring[idx % LineDepth];
    endfunction

    // Kernel walk in fixed order; a set error bit scales the running sum by
    // 257/256 with truncation toward zero.
    function automatic logic [7:0] kernel_sum(input logic [7:0] win [9], input int kern [9],
                                              input logic [7:0] err);
        int s;
        s = int'(win[0]) * kern[0];
        for (int i = 1; i < 9; i++) begin
            s += int'(win[i]) * kern[i];
            if (err[i-1]) begin
                if (s < 0) s = -(((-s) * 257) / 256);
                else s = (s * 257) / 256;
            end
        end
        if (s < 0) s = -s;
        return s[7:0];
    endfunction

    function automatic edge_result_t predict_edge(input int unsigned c, input logic [7:0] eh,
                                                  input logic [7:0] ev);
        int unsigned w, total, col, sq, root;
        logic up, down, left, right;
        logic [7:0] win [9];
        edge_result_t r;
        w     = eff_width();
        total = eff_total();
        col   = c % w;
        up    = c >= w;
        down  = c + w < total;
        left  = col != 0;
        right = col != w - 1;
        win[0] = (up && left)    ? ring_at(c - w - 1) : 8'd0;
        win[1] = up              ? ring_at(c - w)     : 8'd0;
        win[2] = (up && right)   ? ring_at(c - w + 1) : 8'd0;
        win[3] = left            ? ring_at(c - 1)     : 8'd0;
        win[4] = ring_at(c);
        win[5] = right           ? ring_at(c + 1)     : 8'd0;
        win[6] = (down && left)  ? ring_at(c + w - 1) : 8'd0;
        win[7] = down            ? ring_at(c + w)     : 8'd0;
        win[8] = (down && right) ? ring_at(c + w + 1) : 8'd0;
        r.grad_h = kernel_sum(win, KernH, eh);
        r.grad_v = kernel_sum(win, KernV, ev);
        sq = r.grad_h * r.grad_h + r.grad_v * r.grad_v;
        root = 0;
        while ((root + 1) * (root + 1) <= sq) root++;
        r.mag = (root > 255) ? 8'd255 : root[7:0];
        r.frame_end = (c + 1 == total);
        return r;
    endfunction

    always @(posedge i_clk) begin
        int unsigned total;
        edge_result_t got, exp_r;
        logic fire;
        if (!i_rst_n) begin
            width_reg = 640;
            rows_reg  = 480;
            pix_in    = 0;
            res_out   = 0;
            for (int i = 0; i < LineDepth; i++) gray_ring[i] = 8'd0;
            expected_q.delete();
            o_fails   = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LINE_WIDTH) width_reg = i_cfg_data[WidthW-1:0];
                else rows_reg = i_cfg_data[RowsW-1:0];
                pix_in  = 0;
                res_out = 0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                total = eff_total();
                fire  = 1'b0;
                if (!s_axis_tuser && pix_in < total) begin
                    gray_ring[pix_in % LineDepth] =
                        8'((77 * s_axis_tdata[7:0] + 151 * s_axis_tdata[15:8]
                            + 28 * s_axis_tdata[23:16]) >> 8);
                    pix_in++;
                    fire = pix_in >= res_out + eff_width() + 2;
                end else begin
                    fire = pix_in == total && res_out < total;
                end
                if (fire) begin
                    exp_r = predict_edge(res_out, s_axis_tdata[31:24], s_axis_tdata[39:32]);
                    expected_q.push_back(exp_r);
                    res_out++;
                    if (exp_r.frame_end) begin
                        pix_in  = 0;
                        res_out = 0;
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tlast};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %h", $time, got);
                    o_fails++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.grad_h !== exp_r.grad_h) begin
                        $display("%0t: grad_h expected %0d actual %0d", $time,
                                 exp_r.grad_h, got.grad_h);
                        o_fails++;
                    end
                    if (got.grad_v !== exp_r.grad_v) begin
                        $display("%0t: grad_v expected %0d actual %0d", $time,
                                 exp_r.grad_v, got.grad_v);
                        o_fails++;
                    end
                    if (got.mag !== exp_r.mag) begin
                        $display("%0t: magnitude expected %0d actual %0d", $time,
                                 exp_r.mag, got.mag);
                        o_fails++;
                    end
                    if (got.frame_end !== exp_r.frame_end) begin
                        $display("%0t: frame_end expected %0d actual %0d", $time,
                                 exp_r.frame_end, got.frame_end);
                        o_fails++;
                    end
                end
            end
        end
    end

endmodule

@@ dv/approx_sobel_edge_stream_tb.sv @@
// ----------------------------------------------------------------------------
// approx_sobel_edge_stream_tb - stimulus and verdict for the Sobel edge stream
// Writes frame sizes between phases, feeds small frames of random pixels with
// flushes, early flushes and broken frames, and varies idling on both streams.
// A separate monitor predicts and checks every result transfer.
// ----------------------------------------------------------------------------
module approx_sobel_edge_stream_tb;
    import ase_pkg::*;

    localparam int RandomItems = 1550;
    localparam int CycleLimit  = 1000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CfgIdxW-1:0]    i_cfg_idx;
    logic [CfgDataW-1:0]   i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    int fails;
    int pending;
    int cycles;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int unsigned width_now;
    int unsigned rows_now;

    approx_sobel_edge_stream uut (.*);

    sobel_result_monitor mon (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .o_fails(fails), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver stalls at random; its rate follows the current phase.
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready = 1'b0;
        else m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // One transfer on the input stream. The valid stays high between
    // back-to-back transfers and only drops for a sender gap.
    task automatic send_item(input logic flush, input logic [39:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = flush;
        s_axis_tdata  = data;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_pixel();
        send_item(1'b0, {$urandom, $urandom});
    endtask

    task automatic send_flush();
        send_item(1'b1, {$urandom, $urandom});
    endtask

    // Waits until every predicted result has left the block, then lets the
    // block settle.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[CfgDataW-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == CFG_LINE_WIDTH) width_now = val & 12'hFFF;
        else rows_now = val & 13'h1FFF;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned r);
        if ($urandom_range(1)) begin
            write_reg(CFG_LINE_WIDTH, w);
            write_reg(CFG_FRAME_ROWS, r);
        end else begin
            write_reg(CFG_FRAME_ROWS, r);
            write_reg(CFG_LINE_WIDTH, w);
        end
    endtask

    // A whole frame: pixels with occasional early flushes, then as many
    // drain transfers as there are results still owed. Drain transfers are
    // a mix of flushes and surplus pixels, which the block treats as flushes.
    task automatic run_frame(input bit broken);
        int unsigned w, r, total, stop;
        w = (width_now == 0) ? 1 : (width_now > MaxWidth ? MaxWidth : width_now);
        r = (rows_now == 0) ? 1 : (rows_now > MaxRows ? MaxRows : rows_now);
        total = w * r;
        stop  = broken ? $urandom_range(total - 1) : total;
        for (int unsigned p = 0; p < stop; p++) begin
            if ($urandom_range(9) == 0) send_flush();
            send_pixel();
        end
        if (broken) return;
        for (int unsigned d = 0; d < ((total < w + 1) ? total : w + 1); d++) begin
            if ($urandom_range(3) == 0) send_pixel();
            else send_flush();
        end
        // A stray flush after the frame end produces nothing.
        if ($urandom_range(7) == 0) send_flush();
    endtask

    initial begin
        int phase;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_LINE_WIDTH;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        width_now      = 640;
        rows_now       = 480;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part. A 3x3 frame with field extremes: black, white and
        // full error masks, then both drain forms.
        set_frame(3, 3);
        send_item(1'b0, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_item(1'b1, 40'h0);   // early flush: frame not complete, no result
        send_item(1'b0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_item(1'b0, {8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF});
        send_item(1'b0, {8'h00, 8'hFF, 8'h00, 8'h00, 8'h00});
        send_item(1'b0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_item(1'b0, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_item(1'b0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_item(1'b0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_item(1'b0, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_item(1'b0, {8'hA5, 8'h5A, 8'hFF, 8'hFF, 8'hFF});  // full frame in: acts as flush
        send_flush();
        send_flush();
        send_flush();
        // Zero registers act as a single pixel frame.
        set_frame(0, 0);
        send_pixel();
        send_flush();
        // Oversize width and rows clamp; only a handful of pixels go in, so
        // no result appears and the next write restarts the frame.
        set_frame(4095, 8191);
        repeat (4) send_pixel();
        send_flush();
        // Tallest frame with the narrowest line, then the widest line.
        set_frame(1, 4096);
        repeat (6) send_pixel();
        set_frame(2048, 1);
        repeat (3) send_pixel();

        // Random part: phases rotate through the idling patterns.
        phase = 0;
        while (items_sent < RandomItems) begin
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 73; recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 73;
                end
                default: begin
                    send_idle_pct = 27; recv_stall_pct = 27;
                end
            endcase
            if ($urandom_range(15) == 0) set_frame($urandom_range(4095), $urandom_range(3));
            else set_frame($urandom_range(1, 7), $urandom_range(1, 6));
            if (width_now <= 8) begin
                run_frame($urandom_range(9) == 0);
                // Now and then the sender holds off until everything is out.
                if ($urandom_range(3) == 0) drain();
                run_frame(1'b0);
            end else begin
                repeat ($urandom_range(1, 5)) send_pixel();
                send_flush();
            end
            phase++;
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (fails == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule
